@@ hw/rtl/lpt_pkg.sv @@
package lpt_pkg;

    localparam int MAX_RANGE  = 2048;
    localparam int LFSR_BITS  = 12;
    localparam int IDX_W      = $clog2(MAX_RANGE);
    localparam int RNG_W      = IDX_W + 1;
    localparam int SEED_W     = LFSR_BITS;
    localparam int CFG_W      = (RNG_W > SEED_W) ? RNG_W : SEED_W;
    localparam int CMP_W      = (SEED_W > IDX_W) ? SEED_W : IDX_W;
    localparam int WALK_LIMIT = (1 << LFSR_BITS) + 2 * LFSR_BITS;
    localparam int WALK_W     = $clog2(WALK_LIMIT);
    localparam int BL_W       = $clog2(RNG_W + 1);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEED = 1'b1;

    localparam logic [1:0] KIND_LOOKUP  = 2'd0;
    localparam logic [1:0] KIND_SHUFFLE = 2'd1;
    localparam logic [1:0] KIND_REBUILD = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_UNBUILT = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] index;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] value;
        t_status          status;
    } t_rsp;

    typedef struct packed {
        logic             base_we;
        logic [IDX_W-1:0] base_waddr;
        logic [IDX_W-1:0] base_wdata;
        logic [IDX_W-1:0] base_raddr;
        logic             work_we;
        logic [IDX_W-1:0] work_waddr;
        logic [IDX_W-1:0] work_wdata;
        logic [IDX_W-1:0] work_raddr;
    } t_mem_ctl;

    localparam logic [11:0] POLY_TABLE [12] = '{
        12'h001, 12'h003, 12'h006, 12'h00C, 12'h017, 12'h030,
        12'h047, 12'h095, 12'h110, 12'h240, 12'h40B, 12'hE08
    };

    // Clamp a raw range register value into 1..MAX_RANGE.
    function automatic logic [RNG_W-1:0] clamp_range(input logic [RNG_W-1:0] raw);
        logic [RNG_W-1:0] r;
        r = raw;
        if (raw == '0) begin
            r = RNG_W'(1);
        end else if (raw > RNG_W'(MAX_RANGE)) begin
            r = RNG_W'(MAX_RANGE);
        end
        return r;
    endfunction

    // Polynomial picked by the bit length of the range.
    function automatic logic [SEED_W-1:0] poly_for(input logic [RNG_W-1:0] r);
        logic [BL_W-1:0] bl;
        bl = '0;
        for (int k = 0; k < RNG_W; k++) begin
            if (r[k]) begin
                bl = BL_W'(k + 1);
            end
        end
        if (bl > BL_W'(LFSR_BITS)) begin
            bl = BL_W'(LFSR_BITS);
        end
        if (bl < BL_W'(1)) begin
            bl = BL_W'(1);
        end
        return SEED_W'(POLY_TABLE[4'(bl - BL_W'(1))]);
    endfunction

endpackage

@@ hw/rtl/lpt_ram.sv @@
module lpt_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lpt_seq.sv @@
module lpt_seq
    import lpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_req              i_req,
    input  logic [RNG_W-1:0]  i_range_size,
    input  logic [SEED_W-1:0] i_start_seed,
    input  logic [IDX_W-1:0]  i_base_rdata,
    input  logic [IDX_W-1:0]  i_work_rdata,
    output t_mem_ctl          o_mem,
    output logic              o_valid,
    output t_rsp              o_rsp
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FILL  = 5'b00010,
        S_COMP1 = 5'b00100,
        S_COMP2 = 5'b01000,
        S_COMP3 = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [WALK_W-1:0] r_n, n_n;
    logic [SEED_W-1:0] r_lfsr, n_lfsr;
    logic [SEED_W-1:0] r_poly, n_poly;
    logic [IDX_W-1:0]  r_last, n_last;
    logic              r_built, n_built;
    logic              r_src_work, n_src_work;
    logic              r_out_vld, n_out_vld;
    logic              r_out_ram, n_out_ram;
    t_status           r_out_status, n_out_status;

    logic              accept;
    logic [SEED_W-1:0] lfsr_raw;
    logic [SEED_W-1:0] lfsr_step;
    logic [SEED_W-1:0] s_m1;
    logic              hit;
    logic              walk_out;
    logic              last_elem;
    logic [IDX_W-1:0]  first_data;
    logic [RNG_W-1:0]  r_eff;
    logic [IDX_W-1:0]  src_addr;

    assign accept    = i_start && (r_state == S_IDLE);
    assign o_busy    = (r_state != S_IDLE);
    assign lfsr_raw  = {1'b0, r_lfsr[SEED_W-1:1]} ^ (r_lfsr[0] ? r_poly : '0);
    // Reload to one when the register runs into zero.
    assign lfsr_step = (lfsr_raw == '0) ? SEED_W'(1) : lfsr_raw;
    assign s_m1      = lfsr_step - SEED_W'(1);
    assign hit       = CMP_W'(s_m1) <= CMP_W'(r_last);
    assign walk_out  = (r_n == WALK_W'(WALK_LIMIT - 1));
    assign last_elem = (r_i == r_last);
    assign first_data = r_src_work ? i_work_rdata : i_base_rdata;
    assign r_eff     = clamp_range(i_range_size);
    assign src_addr  = (r_state == S_COMP3) ? (r_i + IDX_W'(1)) : r_i;

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_n          = r_n;
        n_lfsr       = r_lfsr;
        n_poly       = r_poly;
        n_last       = r_last;
        n_built      = r_built;
        n_src_work   = r_src_work;
        n_out_vld    = 1'b0;
        n_out_ram    = 1'b0;
        n_out_status = ST_OK;

        o_mem            = '0;
        o_mem.base_waddr = r_i;
        o_mem.base_wdata = hit ? IDX_W'(s_m1) : '0;
        o_mem.base_raddr = r_i;
        o_mem.work_waddr = r_i;
        o_mem.work_wdata = i_base_rdata;
        o_mem.work_raddr = r_i;

        unique case (r_state)
            S_IDLE: begin
                o_mem.work_raddr = i_req.index;
                if (accept) begin
                    unique case (i_req.kind)
                        KIND_LOOKUP: begin
                            n_out_vld = 1'b1;
                            if (!r_built) begin
                                n_out_status = ST_UNBUILT;
                            end else if (i_req.index > r_last) begin
                                n_out_status = ST_RANGE;
                            end else begin
                                n_out_ram = 1'b1;
                            end
                        end
                        KIND_SHUFFLE: begin
                            if (!r_built) begin
                                n_out_vld    = 1'b1;
                                n_out_status = ST_UNBUILT;
                            end else begin
                                n_src_work = 1'b1;
                                n_i        = '0;
                                n_state    = S_COMP1;
                            end
                        end
                        KIND_REBUILD: begin
                            n_last     = IDX_W'(r_eff - RNG_W'(1));
                            n_poly     = poly_for(r_eff);
                            n_lfsr     = i_start_seed;
                            n_i        = '0;
                            n_n        = '0;
                            n_built    = 1'b1;
                            n_src_work = 1'b0;
                            n_state    = S_FILL;
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_FILL: begin
                n_lfsr = lfsr_step;
                // Skip states above the range; give up after the walk limit.
                if (hit || walk_out) begin
                    o_mem.base_we = 1'b1;
                    n_n           = '0;
                    if (last_elem) begin
                        n_i     = '0;
                        n_state = S_COMP1;
                    end else begin
                        n_i = r_i + IDX_W'(1);
                    end
                end else begin
                    n_n = r_n + WALK_W'(1);
                end
            end
            S_COMP1: begin
                o_mem.base_raddr = src_addr;
                o_mem.work_raddr = src_addr;
                n_state          = S_COMP2;
            end
            S_COMP2: begin
                o_mem.base_raddr = first_data;
                n_state          = S_COMP3;
            end
            S_COMP3: begin
                o_mem.work_we = 1'b1;
                if (last_elem) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    // Issue the first read of the next entry.
                    o_mem.base_raddr = src_addr;
                    o_mem.work_raddr = src_addr;
                    n_i              = r_i + IDX_W'(1);
                    n_state          = S_COMP2;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= '0;
            r_built   <= 1'b0;
            r_lfsr    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_built   <= n_built;
            r_lfsr    <= n_lfsr;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_n          <= n_n;
        r_poly       <= n_poly;
        r_src_work   <= n_src_work;
        r_out_ram    <= n_out_ram;
        r_out_status <= n_out_status;
    end

    assign o_valid      = r_out_vld;
    assign o_rsp.value  = r_out_ram ? i_work_rdata : '0;
    assign o_rsp.status = r_out_status;

`ifndef SYNTH
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.base_we |-> (r_state == S_FILL) && (o_mem.base_waddr <= r_last))
        else $error("base write outside fill or past range");

    a_work_wr_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.work_we |-> (r_state == S_COMP3))
        else $error("work write outside compose write step");

    a_rebuild_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.kind == KIND_REBUILD)) |=> o_busy && !o_valid)
        else $error("rebuild request did not start the sequencer");

    a_comp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP2) |=> (r_state == S_COMP3))
        else $error("compose read not followed by write step");

    a_ram_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_ram |-> r_out_vld && (r_out_status == ST_OK))
        else $error("table value driven without an ok lookup result");
`endif

endmodule

@@ hw/rtl/lfsr_permutation_table.sv @@
// Lookup: result strobe in the cycle after the request; one lookup may be issued every cycle.
// Rebuild: busy for the LFSR walk and then the compose pass; the result strobes as busy drops.
// Shuffle (built): busy for a compose pass, paced by the single read port of each table RAM.
// Other requests answer in the cycle after they are taken. Results cannot be stalled.
// Synchronous active-low reset clears control, range 2048, seed 1; table RAMs are not cleared.
module lfsr_permutation_table
    import lpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_valid,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [RNG_W-1:0]  r_range_size;
    logic [SEED_W-1:0] r_start_seed;
    t_mem_ctl          mem;
    logic [IDX_W-1:0]  base_rdata;
    logic [IDX_W-1:0]  work_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_size <= RNG_W'(MAX_RANGE);
            r_start_seed <= SEED_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_SIZE: r_range_size <= RNG_W'(i_cfg_data);
                CFG_START_SEED: r_start_seed <= SEED_W'(i_cfg_data);
            endcase
        end
    end

    lpt_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_req        (i_req),
        .i_range_size (r_range_size),
        .i_start_seed (r_start_seed),
        .i_base_rdata (base_rdata),
        .i_work_rdata (work_rdata),
        .o_mem        (mem),
        .o_valid      (o_valid),
        .o_rsp        (o_rsp)
    );

    lpt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_RANGE)
    ) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (mem.base_we),
        .i_waddr (mem.base_waddr),
        .i_wdata (mem.base_wdata),
        .i_raddr (mem.base_raddr),
        .o_rdata (base_rdata)
    );

    lpt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_RANGE)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (mem.work_we),
        .i_waddr (mem.work_waddr),
        .i_wdata (mem.work_wdata),
        .i_raddr (mem.work_raddr),
        .o_rdata (work_rdata)
    );

endmodule

@@ tb/permutation_checker.sv @@
`timescale 1ns / 1ps
module permutation_checker
    import lpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_req                 i_req,
    input  logic                 i_valid,
    input  t_rsp                 i_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [11:0] TAPS [12] = '{
        12'h001, 12'h003, 12'h006, 12'h00C, 12'h017, 12'h030,
        12'h047, 12'h095, 12'h110, 12'h240, 12'h40B, 12'hE08
    };
    localparam int WALK_STEPS = (1 << LFSR_BITS) + 2 * LFSR_BITS;

    logic [IDX_W-1:0] base_perm [MAX_RANGE];
    logic [IDX_W-1:0] work_perm [MAX_RANGE];
    logic [11:0]      range_reg;
    logic [11:0]      seed_reg;
    int               built_range;
    bit               built;
    t_rsp             due_rsp [$];
    int               fails = 0;

    assign o_fail_count = fails;

    function automatic void rebuild_perm();
        int unsigned r;
        int unsigned nbits;
        int unsigned span;
        int unsigned s;
        int unsigned steps;
        logic [11:0] taps;
        bit          hit;
        r = range_reg;
        if (r == 0) begin
            r = 1;
        end else if (r > MAX_RANGE) begin
            r = MAX_RANGE;
        end
        nbits = 0;
        span  = 1;
        while (span <= r) begin
            span = span << 1;
            nbits++;
        end
        if (nbits > LFSR_BITS) begin
            nbits = LFSR_BITS;
        end
        taps = TAPS[nbits-1];
        s    = seed_reg;
        // walk the Galois register, skip states above the range
        for (int i = 0; i < r; i++) begin
            hit   = 1'b0;
            steps = 0;
            while (!hit && steps < WALK_STEPS) begin
                s = ((s >> 1) ^ (s[0] ? taps : 12'd0)) & 12'hFFF;
                if (s == 0) begin
                    s = 1;
                end
                steps++;
                hit = (s <= r);
            end
            base_perm[i] = hit ? IDX_W'(s - 1) : '0;
        end
        for (int i = 0; i < r; i++) begin
            work_perm[i] = base_perm[base_perm[i]];
        end
        built_range = r;
        built       = 1'b1;
    endfunction

    function automatic t_rsp serve_request(input t_req rq);
        t_rsp rsp;
        rsp.value  = '0;
        rsp.status = ST_OK;
        case (rq.kind)
            KIND_LOOKUP: begin
                if (!built) begin
                    rsp.status = ST_UNBUILT;
                end else if (rq.index >= built_range) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.value = work_perm[rq.index];
                end
            end
            KIND_SHUFFLE: begin
                if (!built) begin
                    rsp.status = ST_UNBUILT;
                end else begin
                    for (int i = 0; i < built_range; i++) begin
                        work_perm[i] = base_perm[work_perm[i]];
                    end
                end
            end
            KIND_REBUILD: begin
                rebuild_perm();
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            range_reg   = 12'd2048;
            seed_reg    = 12'd1;
            built       = 1'b0;
            built_range = 1;
            due_rsp.delete();
        end else begin
            // compare before taking a new request: a result is never for this edge's request
            if (i_valid) begin
                if (due_rsp.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: result with no request outstanding: value %0d status %0d",
                                 $time, i_rsp.value, i_rsp.status);
                    end
                end else begin
                    want = due_rsp.pop_front();
                    if (i_rsp.value !== want.value || i_rsp.status !== want.status) begin
                        fails++;
                        if (fails <= 10) begin
                            $display({"%0t: result mismatch: expected value %0d status %0d,",
                                      " got value %0d status %0d"},
                                     $time, want.value, want.status, i_rsp.value,
                                     i_rsp.status);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RANGE_SIZE) begin
                    range_reg = i_cfg_data[11:0];
                end else if (i_cfg_idx == CFG_START_SEED) begin
                    seed_reg = i_cfg_data[11:0];
                end
            end
            if (i_start && !i_busy) begin
                due_rsp.push_back(serve_request(i_req));
            end
        end
        o_pending <= due_rsp.size();
    end

endmodule

@@ tb/lfsr_permutation_table_tb.sv @@
`timescale 1ns / 1ps
module lfsr_permutation_table_tb;
    import lpt_pkg::*;

    localparam logic [1:0] KIND_NOOP  = 2'd3;
    localparam int         HANG_LIMIT = 40000;
    localparam int         NUM_RANDOM = 1100;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_req                 i_req      = '0;
    logic                 o_valid;
    t_rsp                 o_rsp;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int fail_count;
    int pending;
    int quiet_cycles    = 0;
    int sender_idle_pct = 0;
    int range_shadow    = 2048;
    int live_range      = 1;
    int widest_range    = 0;
    int n_lookup        = 0;
    int n_shuffle       = 0;
    int n_rebuild       = 0;
    int n_noop          = 0;
    int n_writes        = 0;

    always #5 i_clk = ~i_clk;

    lfsr_permutation_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    permutation_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_valid      (o_valid),
        .i_rsp        (o_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", HANG_LIMIT);
            $display("lfsr_permutation_table_tb failed");
            $finish;
        end
    end

    task automatic send(input logic [1:0] op, input int index);
        // drop the request at random, with junk on the payload
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            i_req <= t_req'($urandom);
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= t_req'{kind: op, index: IDX_W'(index)};
        do @(posedge i_clk); while (busy);
        case (op)
            KIND_LOOKUP:  n_lookup++;
            KIND_SHUFFLE: n_shuffle++;
            KIND_REBUILD: begin
                n_rebuild++;
                live_range = (range_shadow == 0) ? 1 :
                             (range_shadow > MAX_RANGE) ? MAX_RANGE : range_shadow;
                if (live_range > widest_range) begin
                    widest_range = live_range;
                end
            end
            default:      n_noop++;
        endcase
    endtask

    // hold off until every result is back and the block is idle, then write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RANGE_SIZE) begin
            range_shadow = value;
        end
        n_writes++;
    endtask

    initial begin
        int n_random;
        int roll;
        int new_range;
        int seg_len;
        int look_idx;

        n_random = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing built yet
        send(KIND_LOOKUP, 0);
        send(KIND_LOOKUP, 2047);
        send(KIND_SHUFFLE, 0);
        send(KIND_NOOP, 0);

        // zero range, seed far wider than the one-bit polynomial
        write_reg(CFG_RANGE_SIZE, 0);
        write_reg(CFG_START_SEED, 12'hFFF);
        send(KIND_REBUILD, 0);
        send(KIND_LOOKUP, 0);
        send(KIND_LOOKUP, 1);
        send(KIND_SHUFFLE, 0);
        send(KIND_LOOKUP, 0);

        // range register above the table size
        write_reg(CFG_RANGE_SIZE, 4095);
        write_reg(CFG_START_SEED, 1);
        send(KIND_REBUILD, 2047);
        send(KIND_LOOKUP, 2047);
        send(KIND_LOOKUP, 0);
        send(KIND_NOOP, 2047);

        write_reg(CFG_RANGE_SIZE, 5);
        write_reg(CFG_START_SEED, 12'h800);
        send(KIND_REBUILD, 0);
        send(KIND_LOOKUP, 4);
        send(KIND_LOOKUP, 5);
        send(KIND_SHUFFLE, 0);
        send(KIND_LOOKUP, 3);

        // new range written but not rebuilt: old range stays in force
        write_reg(CFG_RANGE_SIZE, 300);
        send(KIND_LOOKUP, 5);
        send(KIND_SHUFFLE, 0);
        send(KIND_LOOKUP, 4);

        // register steps through zero and reloads; then a zero seed
        write_reg(CFG_RANGE_SIZE, 3);
        write_reg(CFG_START_SEED, 7);
        send(KIND_REBUILD, 0);
        send(KIND_LOOKUP, 2);
        write_reg(CFG_START_SEED, 0);
        send(KIND_REBUILD, 0);
        send(KIND_LOOKUP, 1);

        while (n_random < NUM_RANDOM) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                new_range = $urandom_range(1) ? MAX_RANGE : $urandom_range(2049, 4095);
            end else if (roll < 12) begin
                new_range = $urandom_range(1025, 2047);
            end else if (roll < 15) begin
                new_range = 0;
            end else begin
                new_range = $urandom_range(1, 64);
            end
            if ($urandom_range(9) != 0) begin
                write_reg(CFG_RANGE_SIZE, new_range);
            end
            if ($urandom_range(9) < 7) begin
                write_reg(CFG_START_SEED, $urandom_range(4095));
            end
            if ($urandom_range(9) != 0) begin
                send(KIND_REBUILD, $urandom_range(2047));
            end
            seg_len = $urandom_range(20, 60);
            repeat (seg_len) begin
                sender_idle_pct = (n_random < NUM_RANDOM / 3) ? 31 :
                                  (n_random < 2 * NUM_RANDOM / 3) ? 69 : 0;
                roll = $urandom_range(99);
                if (roll < 6) begin
                    send(KIND_SHUFFLE, $urandom_range(2047));
                end else if (roll < 9) begin
                    send(KIND_REBUILD, $urandom_range(2047));
                end else if (roll < 13) begin
                    send(KIND_NOOP, $urandom_range(2047));
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 65) begin
                        look_idx = $urandom_range(live_range - 1);
                    end else if (roll < 80) begin
                        look_idx = (live_range < MAX_RANGE && $urandom_range(1)) ?
                                   live_range : live_range - 1;
                    end else begin
                        look_idx = $urandom_range(2047);
                    end
                    send(KIND_LOOKUP, look_idx);
                end
                n_random++;
            end
        end

        sender_idle_pct = 0;
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d lookups, %0d shuffles, %0d rebuilds, %0d unused-kind requests",
                 n_lookup, n_shuffle, n_rebuild, n_noop);
        $display("with %0d register writes; widest table built: %0d entries",
                 n_writes, widest_range);
        if (fail_count == 0 && pending == 0) begin
            $display("lfsr_permutation_table_tb passed");
        end else begin
            $display("lfsr_permutation_table_tb failed");
        end
        $finish;
    end

endmodule
